// ===== design/sepp_pkg.sv =====
package sepp_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int QUEUE_DEPTH = 4;

	localparam int PAN_ONE = 16384;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// register map, word index into the APB space
	typedef enum logic [1:0] {
		REG_MONO_INPUT   = 2'd0,
		REG_USE_BASE_PAN = 2'd1,
		REG_BASE_PAN     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic               mono_input;
		logic               use_base_pan;
		logic signed [15:0] base_pan;
	} cfg_t;

	// classified request: quarter-wave phase (32768 = pi/2), the sample that
	// feeds both multipliers, and the samples added after scaling
	typedef struct packed {
		logic [15:0]        phase;
		logic signed [15:0] samp;
		logic signed [15:0] add_left;
		logic signed [15:0] add_right;
	} pan_req_t;

	// sin of x (Q30 radians) by an 11th-order Taylor sum, rounded to Q1.15
	function automatic logic [15:0] quarter_sine(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [65:0] sum;
		logic [65:0]        r;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed({2'b00, x});
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed({2'b00, term});
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed({2'b00, term});
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed({2'b00, term});
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed({2'b00, term});
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed({2'b00, term});
		if (sum < 0) begin
			sum = '0;
		end
		r = ($unsigned(sum) + 66'd16384) >> 15;
		if (r > 66'd32768) begin
			r = 66'd32768;
		end
		return r[15:0];
	endfunction

endpackage

// ===== design/sepp_front.sv =====
module sepp_front (
	input  sepp_pkg::cfg_t     cfg,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [55:0]        s_tdata,
	input  logic               q_full,
	output logic               q_push,
	output sepp_pkg::pan_req_t q_item
);
	import sepp_pkg::*;

	logic signed [15:0] in_left;
	logic signed [15:0] in_right;
	logic signed [17:0] pan_sample;
	logic signed [17:0] pan_sel;
	logic signed [17:0] pan_c;
	logic signed [17:0] pan_shift;
	logic               fold_left;
	logic               fold_right;

	assign in_left    = s_tdata[15:0];
	assign in_right   = s_tdata[31:16];
	assign pan_sample = s_tdata[49:32];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		pan_sel = cfg.use_base_pan ? 18'(cfg.base_pan) : pan_sample;
		if (pan_sel > 18'sd16384) begin
			pan_c = 18'sd16384;
		end else if (pan_sel < -18'sd16384) begin
			pan_c = -18'sd16384;
		end else begin
			pan_c = pan_sel;
		end
		pan_shift  = pan_c + 18'sd16384;
		fold_left  = !cfg.mono_input && (pan_c <= 18'sd0);
		fold_right = !cfg.mono_input && (pan_c > 18'sd0);

		if (cfg.mono_input) begin
			q_item.phase = pan_shift[15:0];
		end else if (fold_left) begin
			q_item.phase = {pan_shift[14:0], 1'b0};
		end else begin
			q_item.phase = {pan_c[14:0], 1'b0};
		end
		q_item.samp      = fold_left ? in_right : in_left;
		q_item.add_left  = fold_left ? in_left : 16'sd0;
		q_item.add_right = fold_right ? in_right : 16'sd0;
	end

endmodule

// ===== design/sepp_queue.sv =====
module sepp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sepp_pkg::pan_req_t push_item,
	output logic               full,
	input  logic               pop,
	output sepp_pkg::pan_req_t pop_item,
	output logic               not_empty
);
	import sepp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pan_req_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count lost a push");
`endif

endmodule

// ===== design/sepp_back.sv =====
module sepp_back #(
	parameter int SINE_TABLE_DEPTH = sepp_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  sepp_pkg::pan_req_t q_item,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata
);
	import sepp_pkg::*;

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int MULT_W = 16 + IDX_W + 1;
	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SINE_TABLE_DEPTH);

	// quarter-wave sine table, entry k = sin(k*pi/(2*depth)) in Q1.15
	logic [15:0] sine_rom [SINE_TABLE_DEPTH + 1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [63:0] PhaseArg =
			(64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
		assign sine_rom[k] = quarter_sine(PhaseArg);
	end

	logic en_s1, en_s2, en_s3, en_out;
	logic v_s1, v_s2, v_s3, out_valid_q;

	logic [MULT_W-1:0]  idx_full;
	logic [IDX_W-1:0]   idx_s1;
	logic signed [15:0] samp_s1, add_l_s1, add_r_s1;
	logic [15:0]        sin_s2, cos_s2;
	logic signed [15:0] samp_s2, add_l_s2, add_r_s2;
	logic signed [32:0] prod_cos_s3, prod_sin_s3;
	logic signed [15:0] add_l_s3, add_r_s3;
	logic signed [15:0] out_left_q, out_right_q;
	logic signed [18:0] sum_left, sum_right;

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		if (v > 19'sd32767) begin
			return 16'sh7fff;
		end else if (v < -19'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// advance a stage when it is empty or its successor advances
	assign en_out = !out_valid_q || m_tready;
	assign en_s3  = !v_s3 || en_out;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign q_pop  = q_valid && en_s1;

	assign idx_full = MULT_W'(q_item.phase) * MULT_W'(SINE_TABLE_DEPTH) + MULT_W'(16384);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= q_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			idx_s1   <= idx_full[15 +: IDX_W];
			samp_s1  <= q_item.samp;
			add_l_s1 <= q_item.add_left;
			add_r_s1 <= q_item.add_right;
		end
		if (en_s2) begin
			sin_s2   <= sine_rom[idx_s1];
			cos_s2   <= sine_rom[DEPTH_IDX - idx_s1];
			samp_s2  <= samp_s1;
			add_l_s2 <= add_l_s1;
			add_r_s2 <= add_r_s1;
		end
		if (en_s3) begin
			prod_cos_s3 <= 33'(samp_s2) * 33'($signed({1'b0, cos_s2}));
			prod_sin_s3 <= 33'(samp_s2) * 33'($signed({1'b0, sin_s2}));
			add_l_s3    <= add_l_s2;
			add_r_s3    <= add_r_s2;
		end
		if (en_out) begin
			out_left_q  <= sat16(sum_left);
			out_right_q <= sat16(sum_right);
		end
	end

	// round to nearest by adding half an LSB, then floor
	always_comb begin
		logic signed [32:0] rnd_cos;
		logic signed [32:0] rnd_sin;
		rnd_cos   = prod_cos_s3 + 33'sd16384;
		rnd_sin   = prod_sin_s3 + 33'sd16384;
		sum_left  = 19'(add_l_s3) + 19'($signed(rnd_cos[32:15]));
		sum_right = 19'(add_r_s3) + 19'($signed(rnd_sin[32:15]));
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_right_q, out_left_q};

endmodule

// ===== design/stereo_equal_power_panner.sv =====
// Equal-power stereo panner. Each request on the s_ side is one audio frame
// (left, right, per-sample pan); each response on the m_ side is the panned
// frame, saturated to Q1.15. Pan comes from base_pan or from the frame's
// pan_sample, clamped to +/-1.0 (Q2.14 +/-16384). Mono mode spreads the left
// sample over both outputs with cos/sin gains; stereo mode folds one channel
// into the other, pan zero passing the frame through. Gains come from a
// quarter-wave sine table of SINE_TABLE_DEPTH+1 entries, nearest entry, no
// interpolation. The block takes one frame per clock while its queue is not
// full; an accepted frame passes a four-entry queue, then index multiply,
// table read, gain multiply and the output register. The queue decouples
// acceptance from a stalled output, so s_tready stays high behind a held
// response until the three stages before the output register and all four
// queue entries are filled, eight requests in the block. Registers at byte
// addresses 0 (mono_input), 4 (use_base_pan) and 8 (base_pan, read back
// sign-extended); change them only while idle.
module stereo_equal_power_panner #(
	parameter int SINE_TABLE_DEPTH = sepp_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // in_left[15:0], in_right[31:16], pan_sample[49:32]
	// response stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // out_left[15:0], out_right[31:16]
);
	import sepp_pkg::*;

	cfg_t     cfg_q;
	logic     cfg_wr;
	reg_idx_t reg_sel;

	logic     q_full;
	logic     q_push;
	pan_req_t q_in;
	logic     q_pop;
	pan_req_t q_out;
	logic     q_valid;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	// write decode: drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mono_input   <= 1'b0;
			cfg_q.use_base_pan <= 1'b1;
			cfg_q.base_pan     <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_MONO_INPUT:   cfg_q.mono_input   <= pwdata[0];
				REG_USE_BASE_PAN: cfg_q.use_base_pan <= pwdata[0];
				REG_BASE_PAN:     cfg_q.base_pan     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MONO_INPUT:   prdata = {31'd0, cfg_q.mono_input};
			REG_USE_BASE_PAN: prdata = {31'd0, cfg_q.use_base_pan};
			REG_BASE_PAN:     prdata = 32'(cfg_q.base_pan);
			default:          prdata = '0;
		endcase
	end

	// classify the frame: pick and clamp pan, choose the folding rule
	sepp_front u_front (
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	// hold classified requests while the gain pipeline stalls
	sepp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out),
		.not_empty (q_valid)
	);

	// table lookup, gain multiply, fold and saturate
	sepp_back #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_out),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== bench/stereo_equal_power_panner_test.sv =====
// Self-checking bench for the equal-power stereo panner.
//
// A queue of frames feeds a clocked driver on the request side; a clocked
// monitor on the response side pops the oldest predicted frame and compares
// both output channels. Prediction happens at the edge where the block takes
// a request, from the frame itself and a mirror of the three registers. The
// mirror is updated by the APB write task. The gain table is rebuilt here
// from the Taylor series, independently of the package function.
//
// Flow: a handful of directed frames under hand-picked settings, then
// several random phases. Each phase reprograms every register while the
// block is idle. Two phases also stall the response side for a long stretch
// so the request side backs up.
module stereo_equal_power_panner_test;
	import sepp_pkg::*;

	localparam int TABLE_DEPTH      = SINE_TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int DRAIN_CYCLES     = 12;
	localparam int HOLD_CYCLES      = 300;
	localparam int RANDOM_PHASES    = 10;
	localparam int FRAMES_PER_PHASE = 108;
	// word index 3: no register lives there
	localparam logic [3:0] UNUSED_ADDR = 4'd12;

	typedef struct packed {
		logic [17:0] pan_sample;
		logic [15:0] in_right;
		logic [15:0] in_left;
	} frame_t;

	typedef struct packed {
		logic [15:0] out_right;
		logic [15:0] out_left;
	} stereo_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// register mirror and gain table used by the predictor
	cfg_t pan_cfg;
	int   sine_gain [0:TABLE_DEPTH];

	frame_t  frames_to_send [$];
	stereo_t panned_frames  [$];

	bit      sender_gaps   = 1'b1;
	bit      receiver_gaps = 1'b1;
	int      send_gap      = 0;
	int      recv_stall    = 0;
	int      hold_epoch    = 0;
	int      hold_seen     = 0;
	int      hold_left     = 0;
	int      mismatches    = 0;
	int      responses     = 0;
	int      cycle_count   = 0;
	stereo_t got_frame;
	stereo_t want_frame;

	stereo_equal_power_panner #(
		.SINE_TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),    // in_left[15:0], in_right[31:16], pan_sample[49:32]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)     // out_left[15:0], out_right[31:16]
	);

	always #5 clk = ~clk;

	// Quarter-wave sine in Q1.15: Taylor sum to the 11th power in Q30,
	// each term truncated, then rounded to Q15 and clamped to 1.0.
	initial begin : build_gains
		logic [63:0] k;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		int          n;
		for (k = 0; k <= TABLE_DEPTH; k++) begin
			x    = (k * HALF_PI_Q30 + TABLE_DEPTH / 2) / TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (n = 1; n <= 5; n++) begin
				term = ((term * x2) >> 30) / (2 * n * (2 * n + 1));
				if (n % 2 == 1) begin
					sum -= longint'(term);
				end else begin
					sum += longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 16384) >>> 15;
			if (sum > 32768) begin
				sum = 32768;
			end
			sine_gain[k] = int'(sum);
		end
	end

	// sample times gain, rounded half up, floor division by 2^15
	function automatic longint gain_mul(input longint samp, input longint gain);
		return (samp * gain + 64'sd16384) >>> 15;
	endfunction

	function automatic logic [15:0] sat_q15(input longint v);
		if (v > 32767) begin
			v = 32767;
		end
		if (v < -32768) begin
			v = -32768;
		end
		return v[15:0];
	endfunction

	// Panned output of one frame under the current register mirror.
	function automatic stereo_t pan_frame(input frame_t f);
		longint  left;
		longint  right;
		longint  pan;
		longint  phase;
		longint  idx;
		longint  g_sin;
		longint  g_cos;
		longint  mix_l;
		longint  mix_r;
		stereo_t res;
		left  = $signed(f.in_left);
		right = $signed(f.in_right);
		if (pan_cfg.use_base_pan) begin
			pan = $signed(pan_cfg.base_pan);
		end else begin
			pan = $signed(f.pan_sample);
		end
		// clamp to +/-1.0, whatever the source
		if (pan > PAN_ONE) begin
			pan = PAN_ONE;
		end
		if (pan < -PAN_ONE) begin
			pan = -PAN_ONE;
		end
		// phase in [0, 32768], 32768 standing for pi/2
		if (pan_cfg.mono_input) begin
			phase = pan + PAN_ONE;
		end else if (pan <= 0) begin
			phase = 2 * (pan + PAN_ONE);
		end else begin
			phase = 2 * pan;
		end
		idx   = (phase * TABLE_DEPTH + 16384) >>> 15;
		g_sin = sine_gain[idx];
		g_cos = sine_gain[TABLE_DEPTH - idx];
		if (pan_cfg.mono_input) begin
			// spread the left sample over both channels
			mix_l = gain_mul(left, g_cos);
			mix_r = gain_mul(left, g_sin);
		end else if (pan <= 0) begin
			// fold right into left; pan zero passes the frame through
			mix_l = left + gain_mul(right, g_cos);
			mix_r = gain_mul(right, g_sin);
		end else begin
			// fold left into right
			mix_l = gain_mul(left, g_cos);
			mix_r = right + gain_mul(left, g_sin);
		end
		res.out_left  = sat_q15(mix_l);
		res.out_right = sat_q15(mix_r);
		return res;
	endfunction

	function automatic logic [3:0] reg_addr(input reg_idx_t idx);
		return {idx, 2'b00};
	endfunction

	function automatic int pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				return -32768;
			end
			1: begin
				return 32767;
			end
			2: begin
				return 0;
			end
			default: begin
				return int'($urandom_range(0, 65535)) - 32768;
			end
		endcase
	endfunction

	function automatic int pick_pan();
		case ($urandom_range(0, 9))
			0, 1: begin
				// anywhere in the 18-bit field, mostly out of range
				return int'($urandom_range(0, 262143)) - 131072;
			end
			2: begin
				return PAN_ONE;
			end
			3: begin
				return -PAN_ONE;
			end
			4: begin
				return int'($urandom_range(0, 6)) - 3;
			end
			default: begin
				return int'($urandom_range(0, 2 * PAN_ONE)) - PAN_ONE;
			end
		endcase
	endfunction

	task automatic queue_frame(input int left, input int right, input int pan);
		frame_t f;
		f.in_left    = left[15:0];
		f.in_right   = right[15:0];
		f.pan_sample = pan[17:0];
		frames_to_send.push_back(f);
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	// APB write: setup cycle, access cycle; mirror the register at the
	// edge where the block takes it.
	task automatic apb_write(input logic [3:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (addr[1:0] == 2'b00) begin
			case (reg_idx_t'(addr[3:2]))
				REG_MONO_INPUT: begin
					pan_cfg.mono_input = value[0];
				end
				REG_USE_BASE_PAN: begin
					pan_cfg.use_base_pan = value[0];
				end
				REG_BASE_PAN: begin
					pan_cfg.base_pan = value[15:0];
				end
				default: begin
				end
			endcase
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Wait on the falling edge, clear of the clocked processes, until no
	// request is queued or in flight, then let the pipeline settle.
	task automatic wait_drained();
		@(negedge clk);
		while (frames_to_send.size() != 0 || s_tvalid || panned_frames.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Request driver: log the request the block takes at this edge, hold
	// a request that has not been taken, else sit out the drawn gap or
	// present the next frame.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				panned_frames.push_back(pan_frame(frame_t'(s_tdata[49:0])));
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (frames_to_send.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, frames_to_send.pop_front()};
					// gap that follows this request
					send_gap = sender_gaps ? $urandom_range(0, 8) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off on the response side, armed by bumping hold_epoch.
	always @(posedge clk) begin
		if (hold_epoch != hold_seen) begin
			hold_seen <= hold_epoch;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Response monitor: compare each taken response with the oldest
	// prediction, then draw the stall before the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_frame = stereo_t'(m_tdata);
				if (panned_frames.size() == 0) begin
					flag_mismatch($sformatf("response %0d (%h) with no request outstanding",
						responses, m_tdata));
				end else begin
					want_frame = panned_frames.pop_front();
					if (got_frame.out_left !== want_frame.out_left) begin
						flag_mismatch($sformatf("response %0d out_left got %0d want %0d",
							responses, $signed(got_frame.out_left),
							$signed(want_frame.out_left)));
					end
					if (got_frame.out_right !== want_frame.out_right) begin
						flag_mismatch($sformatf("response %0d out_right got %0d want %0d",
							responses, $signed(got_frame.out_right),
							$signed(want_frame.out_right)));
					end
				end
				responses++;
				recv_stall = receiver_gaps ? $urandom_range(0, 8) : 0;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: report failure and end a run that has not finished by CYCLE_LIMIT.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stereo_equal_power_panner_test failed");
		$finish;
	end

	initial begin
		int          ph;
		int          i;
		int          base;
		bit          mono;
		bit          use_base;
		logic [31:0] noise;

		pan_cfg.mono_input   = 1'b0;
		pan_cfg.use_base_pan = 1'b1;
		pan_cfg.base_pan     = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: stereo, base pan zero, so frames pass through.
		queue_frame(-32768, 32767, 0);
		queue_frame(32767, -32768, 0);
		queue_frame(0, -1, 0);
		queue_frame(-1, 0, 5000);
		wait_drained();

		// Per-sample pan in stereo: full left, full right, both sides of
		// zero, and values past +/-1.0 that must clamp.
		noise = $urandom();
		apb_write(reg_addr(REG_USE_BASE_PAN), {noise[31:1], 1'b0});
		queue_frame(32767, 32767, -131072);
		queue_frame(-32768, -32768, -16384);
		queue_frame(32767, -32768, -16385);
		queue_frame(-32768, 32767, 16384);
		queue_frame(32767, 32767, 16385);
		queue_frame(-32768, -32768, 131071);
		queue_frame(12345, -23456, 0);
		queue_frame(-32768, 32767, 1);
		queue_frame(32767, -32768, -1);
		wait_drained();

		// Mono source: right sample must be ignored.
		noise = $urandom();
		apb_write(reg_addr(REG_MONO_INPUT), {noise[31:1], 1'b1});
		queue_frame(-32768, 32767, -131072);
		queue_frame(32767, 0, 0);
		queue_frame(-32768, -1, 131071);
		queue_frame(32767, -32768, 8192);
		wait_drained();

		// Base pan at the register extremes, both clamped; a stray write to
		// the empty slot must change nothing.
		noise = $urandom();
		apb_write(reg_addr(REG_MONO_INPUT), {noise[31:1], 1'b0});
		noise = $urandom();
		apb_write(reg_addr(REG_USE_BASE_PAN), {noise[31:1], 1'b1});
		noise = $urandom();
		apb_write(reg_addr(REG_BASE_PAN), {noise[31:16], 16'h7FFF});
		noise = $urandom();
		apb_write(UNUSED_ADDR, noise);
		queue_frame(32767, -32768, -131072);
		queue_frame(-32768, 32767, 0);
		wait_drained();
		noise = $urandom();
		apb_write(reg_addr(REG_BASE_PAN), {noise[31:16], 16'h8000});
		queue_frame(32767, 32767, 131071);
		queue_frame(-32768, 12345, 0);
		wait_drained();

		// Random phases: fresh settings each time, the first two at base pan
		// -1.0 and +1.0; some phases run without gaps on one side or both.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			sender_gaps   = (ph % 3 != 0);
			receiver_gaps = (ph % 4 != 1);
			mono          = 1'($urandom_range(0, 1));
			use_base      = (ph < 2) ? 1'b1 : 1'($urandom_range(0, 1));
			if (ph == 0) begin
				base = -PAN_ONE;
			end else if (ph == 1) begin
				base = PAN_ONE;
			end else if ($urandom_range(0, 3) == 0) begin
				base = int'($urandom_range(0, 65535)) - 32768;
			end else begin
				base = int'($urandom_range(0, 2 * PAN_ONE)) - PAN_ONE;
			end
			noise = $urandom();
			apb_write(reg_addr(REG_MONO_INPUT), {noise[31:1], mono});
			noise = $urandom();
			apb_write(reg_addr(REG_USE_BASE_PAN), {noise[31:1], use_base});
			noise = $urandom();
			apb_write(reg_addr(REG_BASE_PAN), {noise[31:16], base[15:0]});
			if (ph % 4 == 3) begin
				noise = $urandom();
				apb_write(UNUSED_ADDR, noise);
			end
			for (i = 0; i < FRAMES_PER_PHASE; i++) begin
				queue_frame(pick_sample(), pick_sample(), pick_pan());
			end
			// back the block up while the driver keeps offering requests
			if (ph == 2 || ph == 7) begin
				hold_epoch <= hold_epoch + 1;
			end
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("stereo_equal_power_panner_test passed");
		end else begin
			$display("stereo_equal_power_panner_test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/sepp_pkg.sv
design/sepp_front.sv
design/sepp_queue.sv
design/sepp_back.sv
design/stereo_equal_power_panner.sv
bench/stereo_equal_power_panner_test.sv
